/* rtl/m3i_pkg.sv */
// Shared types for the 3x3 matrix inverse block.
// Used by the divider lane and the top level; depends on nothing.
`default_nettype none
package m3i_pkg;

    // Side information that travels beside each quotient through a divider lane.
    typedef struct packed {
        logic neg;   // result takes a negative sign
        logic ovf;   // quotient does not fit the quotient register
    } lane_ctl_t;

endpackage
`default_nettype wire

/* rtl/m3i_in_if.sv */
// Input channel of the matrix inverse block: one 3x3 matrix per transfer.
// Depends on nothing.
`default_nettype none
interface m3i_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] a_r0_c0;
    logic signed [DATA_WIDTH-1:0] a_r0_c1;
    logic signed [DATA_WIDTH-1:0] a_r0_c2;
    logic signed [DATA_WIDTH-1:0] a_r1_c0;
    logic signed [DATA_WIDTH-1:0] a_r1_c1;
    logic signed [DATA_WIDTH-1:0] a_r1_c2;
    logic signed [DATA_WIDTH-1:0] a_r2_c0;
    logic signed [DATA_WIDTH-1:0] a_r2_c1;
    logic signed [DATA_WIDTH-1:0] a_r2_c2;

    modport source (
        output valid, a_r0_c0, a_r0_c1, a_r0_c2, a_r1_c0, a_r1_c1, a_r1_c2,
               a_r2_c0, a_r2_c1, a_r2_c2,
        input  ready
    );
    modport sink (
        input  valid, a_r0_c0, a_r0_c1, a_r0_c2, a_r1_c0, a_r1_c1, a_r1_c2,
               a_r2_c0, a_r2_c1, a_r2_c2,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/m3i_out_if.sv */
// Output channel of the matrix inverse block: inverse, determinant and flags.
// Depends on nothing.
`default_nettype none
interface m3i_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] inv_r0_c0;
    logic signed [DATA_WIDTH-1:0] inv_r0_c1;
    logic signed [DATA_WIDTH-1:0] inv_r0_c2;
    logic signed [DATA_WIDTH-1:0] inv_r1_c0;
    logic signed [DATA_WIDTH-1:0] inv_r1_c1;
    logic signed [DATA_WIDTH-1:0] inv_r1_c2;
    logic signed [DATA_WIDTH-1:0] inv_r2_c0;
    logic signed [DATA_WIDTH-1:0] inv_r2_c1;
    logic signed [DATA_WIDTH-1:0] inv_r2_c2;
    logic signed [DATA_WIDTH-1:0] det_value;
    logic                         singular;
    logic                         saturated;

    modport source (
        output valid, inv_r0_c0, inv_r0_c1, inv_r0_c2, inv_r1_c0, inv_r1_c1,
               inv_r1_c2, inv_r2_c0, inv_r2_c1, inv_r2_c2, det_value, singular,
               saturated,
        input  ready
    );
    modport sink (
        input  valid, inv_r0_c0, inv_r0_c1, inv_r0_c2, inv_r1_c0, inv_r1_c1,
               inv_r1_c2, inv_r2_c0, inv_r2_c1, inv_r2_c2, det_value, singular,
               saturated,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/matrix3_inverse_unit.sv */
// Top level of the 3x3 matrix inverse (adjugate over determinant).
// Depends on m3i_pkg, m3i_in_if, m3i_out_if and m3i_div_lane.
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | a_r0_c0 .. a_r2_c2, signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS
//  out_ch   | out | inv_r0_c0 .. inv_r2_c2, det_value, singular, saturated
//
// One matrix is taken every cycle while no result waits in the skid register.
// The pipeline has five cofactor/determinant stages, DATA_WIDTH + 1 divider stages
// (one quotient bit each) and the output register.
// Reset clears the valid bits only; no clearing pass.
// A stall on out_ch parks one result in a skid register and then holds the pipeline.
`default_nettype none
module matrix3_inverse_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    m3i_in_if.sink    in_ch,
    m3i_out_if.source out_ch
);
    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int CW   = 2*W + 1;
    localparam int DW   = 3*W + 3;
    localparam int LWA  = 4*W + 6;
    localparam int LWB  = 2*W + 2*F + 4;
    localparam int LW   = (LWA > LWB) ? LWA : LWB;
    localparam int NDIV = W + 1;
    localparam int NS   = 5 + NDIV;
    localparam int RW   = 10*W + 2;
    localparam logic [DW-1:0] DLIM = DW'(1) << (W-1);
    localparam logic [DW-1:0] HALF = DW'(1) << (2*F-1);

    logic en;
    logic [NS-1:0] v_reg;
    logic out_v_reg, skid_v_reg;
    logic [RW-1:0] out_reg, skid_reg, res;

    assign en          = !skid_v_reg;
    assign in_ch.ready = en;

    logic signed [W-1:0] a_el [3][3];
    assign a_el[0][0] = in_ch.a_r0_c0;
    assign a_el[0][1] = in_ch.a_r0_c1;
    assign a_el[0][2] = in_ch.a_r0_c2;
    assign a_el[1][0] = in_ch.a_r1_c0;
    assign a_el[1][1] = in_ch.a_r1_c1;
    assign a_el[1][2] = in_ch.a_r1_c2;
    assign a_el[2][0] = in_ch.a_r2_c0;
    assign a_el[2][1] = in_ch.a_r2_c1;
    assign a_el[2][2] = in_ch.a_r2_c2;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], in_ch.valid};
    end

    // stage 1: the 18 element products
    logic signed [2*W-1:0] pa_reg [3][3];
    logic signed [2*W-1:0] pb_reg [3][3];
    logic signed [W-1:0]   c0_s1_reg [3];
    logic signed [W-1:0]   c0_s2_reg [3];
    logic signed [CW-1:0]  cof_s2_reg [3][3];

    genvar gi, gr;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_cof
            for (gr = 0; gr < 3; gr++)
            begin : g_comp
                localparam int P  = (gi + 1) % 3;
                localparam int S  = (gi + 2) % 3;
                localparam int R1 = (gr + 1) % 3;
                localparam int R2 = (gr + 2) % 3;
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        pa_reg[gi][gr]     <= a_el[R1][P] * a_el[R2][S];
                        pb_reg[gi][gr]     <= a_el[R2][P] * a_el[R1][S];
                        cof_s2_reg[gi][gr] <= CW'(pa_reg[gi][gr]) - CW'(pb_reg[gi][gr]);
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                c0_s1_reg[r] <= a_el[r][0];
                c0_s2_reg[r] <= c0_s1_reg[r];
            end
        end
    end

    // stage 3: determinant partial products, cofactor split at bit W
    logic signed [CW-1:0] plo_reg [3];
    logic signed [CW-1:0] phi_reg [3];
    logic signed [CW-1:0] cof_s3_reg [3][3];
    logic signed [CW-1:0] cof_s4_reg [3][3];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                plo_reg[r] <= c0_s2_reg[r] * $signed({1'b0, cof_s2_reg[0][r][W-1:0]});
                phi_reg[r] <= c0_s2_reg[r] * $signed(cof_s2_reg[0][r][2*W:W]);
            end
            cof_s3_reg <= cof_s2_reg;
            cof_s4_reg <= cof_s3_reg;
            det_reg    <= det_next;
        end
    end

    // stage 4: sum the partial products into the exact determinant
    always_comb
    begin
        logic signed [DW-1:0] hi;
        logic signed [DW-1:0] lo;
        det_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            hi       = DW'(phi_reg[r]);
            lo       = DW'(plo_reg[r]);
            det_next = det_next + (hi <<< W) + lo;
        end
    end

    // stage 5: magnitudes for the divider, rounded determinant, flags
    logic [LW-1:0]      num_reg [3][3];
    logic [LW-1:0]      den_reg;
    m3i_pkg::lane_ctl_t ctl_reg [3][3];
    logic [W-1:0]       detv_reg;
    logic               dsat_reg;
    logic               sing_reg;

    logic [DW-1:0] dmag, drnd;
    logic [W-1:0]  detv_next;
    logic          dsat_next;
    logic [DW-1:0] dneg;
    logic [LW-1:0] dmag_l;

    assign dmag   = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
    assign drnd   = (dmag + HALF) >> (2*F);
    assign dneg   = DW'(0) - drnd;
    assign dmag_l = LW'(dmag);

    always_comb
    begin
        if (det_reg[DW-1])
        begin
            dsat_next = (drnd > DLIM);
            detv_next = dsat_next ? DLIM[W-1:0] : dneg[W-1:0];
        end
        else
        begin
            dsat_next = (drnd > DLIM - DW'(1));
            detv_next = dsat_next ? (DLIM[W-1:0] - W'(1)) : drnd[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    // rounding: floor((2n + m) / 2m) with n = |cof| << 2F
                    num_reg[i][c] <= (LW'(cof_s4_reg[i][c][CW-1]
                                          ? CW'(-cof_s4_reg[i][c])
                                          : CW'(cof_s4_reg[i][c])) << (2*F+1))
                                     + dmag_l;
                    ctl_reg[i][c].neg <= cof_s4_reg[i][c][CW-1] ^ det_reg[DW-1];
                    ctl_reg[i][c].ovf <= 1'b0;
                end
            end
            den_reg  <= dmag_l << 1;
            detv_reg <= detv_next;
            dsat_reg <= dsat_next;
            sing_reg <= (det_reg == '0);
        end
    end

    // divider lanes and the side line that runs beside them
    logic [W-1:0] q_lane [3][3];
    logic         s_lane [3][3];
    logic [W-1:0] detv_line_reg [NDIV];
    logic         dsat_line_reg [NDIV];
    logic         sing_line_reg [NDIV];

    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_row
            for (gr = 0; gr < 3; gr++)
            begin : g_col
                m3i_div_lane #(
                    .W  (W),
                    .LW (LW)
                ) u_lane (
                    .clk (clk),
                    .en  (en),
                    .num (num_reg[gi][gr]),
                    .den (den_reg),
                    .ctl (ctl_reg[gi][gr]),
                    .q   (q_lane[gi][gr]),
                    .sat (s_lane[gi][gr])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            detv_line_reg[0] <= detv_reg;
            dsat_line_reg[0] <= dsat_reg;
            sing_line_reg[0] <= sing_reg;
            for (int k = 1; k < NDIV; k++)
            begin
                detv_line_reg[k] <= detv_line_reg[k-1];
                dsat_line_reg[k] <= dsat_line_reg[k-1];
                sing_line_reg[k] <= sing_line_reg[k-1];
            end
        end
    end

    // assemble the result; a singular matrix drops the inverse, determinant and saturated flag to zero
    always_comb
    begin
        logic any_sat;
        logic sing;
        any_sat = dsat_line_reg[NDIV-1];
        sing    = sing_line_reg[NDIV-1];
        res     = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                any_sat = any_sat | s_lane[i][c];
                res[RW-1-(i*3+c)*W -: W] = sing ? W'(0) : q_lane[i][c];
            end
        end
        res[W+1:2] = sing ? W'(0) : detv_line_reg[NDIV-1];
        res[1]     = sing;
        res[0]     = any_sat & !sing;
    end

    // output register with a skid stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (skid_v_reg)
            begin
                if (out_ch.ready)
                    skid_v_reg <= 1'b0;
            end
            else if (v_reg[NS-1] && out_v_reg && !out_ch.ready)
                skid_v_reg <= 1'b1;
            if (skid_v_reg)
                out_v_reg <= 1'b1;
            else if (!out_v_reg || out_ch.ready)
                out_v_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_ch.ready)
                out_reg <= skid_reg;
        end
        else if (!out_v_reg || out_ch.ready)
            out_reg <= res;
        else
            skid_reg <= res;
    end

    assign out_ch.valid     = out_v_reg;
    assign out_ch.inv_r0_c0 = out_reg[RW-1-0*W -: W];
    assign out_ch.inv_r0_c1 = out_reg[RW-1-1*W -: W];
    assign out_ch.inv_r0_c2 = out_reg[RW-1-2*W -: W];
    assign out_ch.inv_r1_c0 = out_reg[RW-1-3*W -: W];
    assign out_ch.inv_r1_c1 = out_reg[RW-1-4*W -: W];
    assign out_ch.inv_r1_c2 = out_reg[RW-1-5*W -: W];
    assign out_ch.inv_r2_c0 = out_reg[RW-1-6*W -: W];
    assign out_ch.inv_r2_c1 = out_reg[RW-1-7*W -: W];
    assign out_ch.inv_r2_c2 = out_reg[RW-1-8*W -: W];
    assign out_ch.det_value = out_reg[W+1:2];
    assign out_ch.singular  = out_reg[1];
    assign out_ch.saturated = out_reg[0];

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && out_ch.ready) |=> !skid_v_reg && out_v_reg)
        else $error("skid result not moved to the output register");

    a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_ch.singular) |-> (!out_ch.saturated && out_ch.det_value == '0))
        else $error("singular result carries a determinant or saturation");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved while held");
endmodule
`default_nettype wire

/* rtl/m3i_div_lane.sv */
// Pipelined restoring divider lane: one quotient bit per stage, rounded
// quotient saturated to W bits. Depends on m3i_pkg.
`default_nettype none
module m3i_div_lane #(
    parameter int W  = 32,
    parameter int LW = 134
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [LW-1:0]      num,
    input  wire logic [LW-1:0]      den,
    input  wire m3i_pkg::lane_ctl_t ctl,
    output logic [W-1:0]            q,
    output logic                    sat
);
    localparam int NST = W + 1;
    localparam logic [W:0] LIM = (W+1)'(1) << (W-1);

    logic [LW-1:0]      rem_in [NST];
    logic [LW-1:0]      den_in [NST];
    logic [W:0]         quo_in [NST];
    m3i_pkg::lane_ctl_t ctl_in [NST];

    logic [LW-1:0]      rem_reg [NST];
    logic [LW-1:0]      den_reg [NST];
    logic [W:0]         quo_reg [NST];
    m3i_pkg::lane_ctl_t ctl_reg [NST];

    assign rem_in[0] = num;
    assign den_in[0] = den;
    assign quo_in[0] = '0;
    always_comb
    begin
        ctl_in[0]     = ctl;
        // quotient would reach 2^(W+1): mark as overflow at once
        ctl_in[0].ovf = (num >= (den << (W+1)));
    end

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_stage
            logic [LW-1:0] dsh;
            logic          ge;
            assign dsh = den_in[k] << (W-k);
            assign ge  = (rem_in[k] >= dsh);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (rem_in[k] - dsh) : rem_in[k];
                    den_reg[k] <= den_in[k];
                    quo_reg[k] <= {quo_in[k][W-1:0], ge};
                    ctl_reg[k] <= ctl_in[k];
                end
            end
            if (k > 0)
            begin : g_link
                assign rem_in[k] = rem_reg[k-1];
                assign den_in[k] = den_reg[k-1];
                assign quo_in[k] = quo_reg[k-1];
                assign ctl_in[k] = ctl_reg[k-1];
            end
        end
    endgenerate

    logic [W:0] qf;
    logic [W:0] qneg;
    assign qf   = quo_reg[NST-1];
    assign qneg = (W+1)'(0) - qf;

    always_comb
    begin
        if (ctl_reg[NST-1].neg)
        begin
            sat = ctl_reg[NST-1].ovf || (qf > LIM);
            q   = sat ? LIM[W-1:0] : qneg[W-1:0];
        end
        else
        begin
            sat = ctl_reg[NST-1].ovf || (qf > LIM - (W+1)'(1));
            q   = sat ? (LIM[W-1:0] - W'(1)) : qf[W-1:0];
        end
    end
endmodule
`default_nettype wire

/* tb/sv/m3i_inverse_checker.sv */
// Scoreboard for the 3x3 matrix inverse block: watches both channels, works out
// each expected inverse from the accepted matrix and compares every result.
// Depends on m3i_in_if and m3i_out_if.
`default_nettype none
module m3i_inverse_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    m3i_in_if         in_mon,
    m3i_out_if        out_mon,
    output int        mismatches,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] field [10];   // nine inverse elements, then the determinant
        logic        singular;
        logic        saturated;
    } inverse_t;

    inverse_t inverse_q [$];

    // round(num / den), ties away from zero, clipped to 32 signed bits
    function automatic logic [31:0] round_div(input logic signed [127:0] num,
                                              input logic signed [127:0] den,
                                              inout bit clip);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        bit           neg;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        q   = ((un << 1) + ud) / (ud << 1);
        if (neg)
        begin
            if (q > 128'h8000_0000)
            begin
                q    = 128'h8000_0000;
                clip = 1'b1;
            end
            q = -q;
        end
        else if (q > 128'h7fff_ffff)
        begin
            q    = 128'h7fff_ffff;
            clip = 1'b1;
        end
        return q[31:0];
    endfunction

    function automatic inverse_t predict_inverse(input logic signed [31:0] m [9]);
        logic signed [127:0] e [3][3];
        logic signed [127:0] cof [3][3];
        logic signed [127:0] det;
        logic signed [127:0] scale;
        inverse_t            r;
        bit                  clip;
        int                  p, s, r1, r2;
        clip  = 1'b0;
        scale = 128'sh1_0000_0000;
        for (int i = 0; i < 9; i++)
            e[i / 3][i % 3] = m[i];
        // cofactor row i is column (i+1) crossed with column (i+2)
        for (int i = 0; i < 3; i++)
        begin
            p = (i + 1) % 3;
            s = (i + 2) % 3;
            for (int k = 0; k < 3; k++)
            begin
                r1 = (k + 1) % 3;
                r2 = (k + 2) % 3;
                cof[i][k] = e[r1][p] * e[r2][s] - e[r2][p] * e[r1][s];
            end
        end
        det = 0;
        for (int k = 0; k < 3; k++)
            det = det + e[k][0] * cof[0][k];
        for (int i = 0; i < 10; i++)
            r.field[i] = '0;
        r.singular  = (det == 0);
        r.saturated = 1'b0;
        if (det != 0)
        begin
            r.field[9] = round_div(det, scale, clip);
            for (int i = 0; i < 9; i++)
                r.field[i] = round_div(cof[i / 3][i % 3] * scale, det, clip);
            r.saturated = clip;
        end
        return r;
    endfunction

    string field_name [10] = '{"inv_r0_c0", "inv_r0_c1", "inv_r0_c2", "inv_r1_c0",
                               "inv_r1_c1", "inv_r1_c2", "inv_r2_c0", "inv_r2_c1",
                               "inv_r2_c2", "det_value"};

    always @(posedge clk)
    begin : watch
        logic signed [31:0] mat [9];
        inverse_t           want;
        logic [31:0]        got [10];
        bit                 bad;
        if (rst_n && in_mon.valid && in_mon.ready)
        begin
            mat = '{in_mon.a_r0_c0, in_mon.a_r0_c1, in_mon.a_r0_c2,
                    in_mon.a_r1_c0, in_mon.a_r1_c1, in_mon.a_r1_c2,
                    in_mon.a_r2_c0, in_mon.a_r2_c1, in_mon.a_r2_c2};
            inverse_q.push_back(predict_inverse(mat));
        end
        if (rst_n && out_mon.valid && out_mon.ready)
        begin
            if (inverse_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transfer with nothing outstanding", $realtime);
            end
            else
            begin
                want = inverse_q.pop_front();
                got  = '{out_mon.inv_r0_c0, out_mon.inv_r0_c1, out_mon.inv_r0_c2,
                         out_mon.inv_r1_c0, out_mon.inv_r1_c1, out_mon.inv_r1_c2,
                         out_mon.inv_r2_c0, out_mon.inv_r2_c1, out_mon.inv_r2_c2,
                         out_mon.det_value};
                bad  = (want.singular !== out_mon.singular)
                    || (want.saturated !== out_mon.saturated);
                for (int i = 0; i < 10; i++)
                    if (got[i] !== want.field[i])
                        bad = 1'b1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: inverse mismatch", $realtime);
                        for (int i = 0; i < 10; i++)
                            if (got[i] !== want.field[i])
                                $display("  %s expected %h got %h", field_name[i],
                                         want.field[i], got[i]);
                        if (want.singular !== out_mon.singular)
                            $display("  singular expected %b got %b", want.singular,
                                     out_mon.singular);
                        if (want.saturated !== out_mon.saturated)
                            $display("  saturated expected %b got %b", want.saturated,
                                     out_mon.saturated);
                    end
                end
            end
        end
        pending <= inverse_q.size();
    end
endmodule
`default_nettype wire

/* tb/sv/tb_matrix3_inverse_unit.sv */
// Top of the matrix inverse testbench: clock, reset, matrix stimulus and
// result back-pressure, with the verdict. Depends on the RTL interfaces,
// matrix3_inverse_unit and m3i_inverse_checker.
`default_nettype none
module tb_matrix3_inverse_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 1400;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 48;   // pipeline depth plus margin
    localparam logic [31:0] ONE          = 32'h0001_0000;
    localparam logic [31:0] MAXV         = 32'h7fff_ffff;
    localparam logic [31:0] MINV         = 32'h8000_0000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   idle_cycles;
    bit   in_burst;
    bit   out_burst;

    m3i_in_if  #(.DATA_WIDTH(32)) in_ch ();
    m3i_out_if #(.DATA_WIDTH(32)) out_ch ();

    matrix3_inverse_unit #(.DATA_WIDTH(32), .FRAC_BITS(16)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    m3i_inverse_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_matrix(input logic [31:0] m [9]);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.a_r0_c0 <= m[0];
        in_ch.a_r0_c1 <= m[1];
        in_ch.a_r0_c2 <= m[2];
        in_ch.a_r1_c0 <= m[3];
        in_ch.a_r1_c1 <= m[4];
        in_ch.a_r1_c2 <= m[5];
        in_ch.a_r2_c0 <= m[6];
        in_ch.a_r2_c1 <= m[7];
        in_ch.a_r2_c2 <= m[8];
        do @(posedge clk); while (!in_ch.ready);
    endtask

    function automatic logic [31:0] small_value(input int span);
        return 32'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return MAXV;
            1: return MINV;
            2: return '0;
            3: return ONE;
            4: return -ONE;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_matrix();
        logic [31:0] m [9];
        int          kind;
        int          src;
        int          dst;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
        begin
            case (kind)
                0, 1:    m[i] = $urandom;
                2, 3, 4: m[i] = small_value(1 << 18);                 // within +/-4.0
                5:       m[i] = ((i % 4) == 0 ? ONE : '0) + small_value(1 << 12);
                6:       m[i] = small_value(8);                        // tiny determinant
                7:       m[i] = pick_extreme();
                default: m[i] = small_value(1 << 20);
            endcase
        end
        // make it singular by repeating or negating a row or a column
        if (kind >= 8)
        begin
            src = $urandom_range(0, 2);
            dst = (src + $urandom_range(1, 2)) % 3;
            for (int k = 0; k < 3; k++)
                if (kind == 8)
                    m[dst * 3 + k] = m[src * 3 + k];
                else
                    m[k * 3 + dst] = -m[k * 3 + src];
        end
        send_matrix(m);
    endtask

    // back-pressure on the result channel
    initial
    begin : result_stall
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] m [9];
        in_burst       = 1'b0;
        out_burst      = 1'b0;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.a_r0_c0 <= '0;
        in_ch.a_r0_c1 <= '0;
        in_ch.a_r0_c2 <= '0;
        in_ch.a_r1_c0 <= '0;
        in_ch.a_r1_c1 <= '0;
        in_ch.a_r1_c2 <= '0;
        in_ch.a_r2_c0 <= '0;
        in_ch.a_r2_c1 <= '0;
        in_ch.a_r2_c2 <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, zero, extremes, tiny and rank-deficient cases
        m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};            send_matrix(m);
        m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};         send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send_matrix(m);
        m = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}; send_matrix(m);
        m = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}; send_matrix(m);
        m = '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV};         send_matrix(m);
        m = '{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV};         send_matrix(m);
        m = '{MINV, 0, 0, 0, MAXV, 0, 0, 0, MINV};         send_matrix(m);
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                  send_matrix(m);
        m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};            send_matrix(m);
        m = '{2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, -8 * ONE}; send_matrix(m);
        m = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
              7 * ONE, 8 * ONE, 9 * ONE};                  send_matrix(m);
        m = '{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE,
              5 * ONE, 6 * ONE, 0};                        send_matrix(m);
        m = '{3, 0, 0, 0, ONE, 0, 0, 0, ONE};              send_matrix(m);
        m = '{MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, ONE};    send_matrix(m);
        m = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV}; send_matrix(m);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // alternate stretches with and without idling
            if ((n % 64) == 0)
            begin
                in_burst  = ($urandom_range(0, 3) == 0);
                out_burst = ($urandom_range(0, 3) == 0);
            end
            send_random_matrix();
        end
        in_ch.valid <= 1'b0;
        out_burst = 1'b0;

        // let the count of outstanding items take in the last transfer
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
